// File: hdl/windowed_min_base_delay_tracker_assert.svh
// assertion macros used by the checker file
`ifndef WINDOWED_MIN_BASE_DELAY_TRACKER_ASSERT_SVH
`define WINDOWED_MIN_BASE_DELAY_TRACKER_ASSERT_SVH

// same-cycle implication
`define WMBDT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same cycle implication");

// next-cycle implication
`define WMBDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next cycle implication");

`endif

// File: hdl/wmbdt_pkg.sv
// shared constants, types, the wrap-order compare and the ring index step for the base delay tracker
package wmbdt_pkg;

   localparam int HISTORY_DEPTH = 20;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = $clog2(HISTORY_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

   typedef logic [DATA_W-1:0] delay_type;
   typedef logic [IDX_W-1:0]  index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK,
      ST_SCAN
   } state_type;

   // a before b when the forward distance is the shorter one
   function automatic logic wrap_less(input delay_type a, input delay_type b);
      delay_type up;
      delay_type down;
      up   = b - a;
      down = a - b;
      return up < down;
   endfunction

   function automatic index_type next_index(input index_type idx);
      return (idx == LAST_IDX) ? '0 : idx + index_type'(1);
   endfunction

endpackage

// File: hdl/windowed_min_base_delay_tracker.sv
// windowed minimum base delay tracker: bucket ring in ram, base and index in flops
// a result is registered in the look state once the output register is free; the first sample after
//   reset first passes the fill state, writing every bucket through the one write port
// a new sample is taken only in the idle state (read bucket, then merge); a step sample then
//   rescans the ring in the scan state, one bucket per cycle on the ram read port
// reset clears state, index, primed and the result valid; ring and base are filled by
//   the first sample
module windowed_min_base_delay_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wmbdt_pkg::delay_type  req_sample,
   input  logic                  req_step,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wmbdt_pkg::delay_type  rsp_delay_over_base
);
   import wmbdt_pkg::*;

   state_type state_ff, state_in;
   logic      primed_ff, primed_in;
   delay_type base_ff, base_in;
   index_type index_ff, index_in;
   delay_type sample_ff, sample_in;
   logic      step_ff, step_in;
   index_type cnt_ff, cnt_in;
   logic      issue_ff, issue_in;
   logic      rd_valid_ff, rd_valid_in;
   index_type rd_addr_ff, rd_addr_in;
   logic      rsp_valid_ff, rsp_valid_in;
   delay_type rsp_data_ff, rsp_data_in;

   logic      wr_en;
   index_type wr_addr;
   delay_type wr_data;
   index_type rd_addr;
   delay_type rd_data;

   logic      out_free;
   logic      lower_base;
   logic      lower_bkt;
   delay_type merged_base;
   delay_type scan_val;

   wmbdt_ram #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (DATA_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign lower_base  = wrap_less(sample_ff, base_ff);
   assign lower_bkt   = wrap_less(sample_ff, rd_data);
   assign merged_base = lower_base ? sample_ff : base_ff;
   // the bucket just advanced to holds the sample, whatever the ram still returns
   assign scan_val    = (rd_addr_ff == index_ff) ? sample_ff : rd_data;

   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      base_in      = base_ff;
      index_in     = index_ff;
      sample_in    = sample_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_addr_in   = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = index_ff;
      wr_data      = sample_ff;
      rd_addr      = index_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sample_in = req_sample;
               step_in   = req_step;
               cnt_in    = '0;
               state_in  = primed_ff ? ST_LOOK : ST_FILL;
            end
         end

         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            base_in = sample_ff;
            cnt_in  = cnt_ff + index_type'(1);
            if (cnt_ff == LAST_IDX) begin
               primed_in = 1'b1;
               state_in  = ST_LOOK;
            end
         end

         ST_LOOK: begin
            if (out_free) begin
               wr_en        = lower_base || lower_bkt;
               rsp_valid_in = 1'b1;
               rsp_data_in  = sample_ff - merged_base;
               base_in      = merged_base;
               if (step_ff) begin
                  index_in = next_index(index_ff);
                  base_in  = sample_ff;
                  cnt_in   = '0;
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SCAN: begin
            if (issue_ff) begin
               rd_addr     = cnt_ff;
               rd_valid_in = 1'b1;
               rd_addr_in  = cnt_ff;
               cnt_in      = cnt_ff + index_type'(1);
               if (cnt_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end
               // new bucket takes the sample on the first scan cycle
               wr_en = (cnt_ff == '0);
            end
            if (rd_valid_ff) begin
               if (wrap_less(scan_val, base_ff)) begin
                  base_in = scan_val;
               end
               if (rd_addr_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         index_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         index_ff     <= index_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      sample_ff   <= sample_in;
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_delay_over_base = rsp_data_ff;

endmodule

// File: hdl/wmbdt_ram.sv
// generic single write, single read port ram with registered read data
module wmbdt_ram #(
   parameter int DEPTH = 20,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/wmbdt_checker.sv
// port level checks for the base delay tracker, bound to the top level
`include "windowed_min_base_delay_tracker_assert.svh"

module wmbdt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input wmbdt_pkg::delay_type  req_sample,
   input logic                  req_step,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input wmbdt_pkg::delay_type  rsp_delay_over_base
);
   import wmbdt_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       first_ff, first_in;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       unused_payload;

   assign req_xfer       = req_valid && req_ready;
   assign rsp_xfer       = rsp_valid && rsp_ready;
   assign unused_payload = ^{req_sample, req_step};

   always_comb begin
      pend_in  = pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
      first_in = first_ff && !rsp_xfer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         pend_ff  <= pend_in;
         first_ff <= first_in;
      end
   end

   // a result only for a sample taken and not yet answered
   `WMBDT_ASSERT_SAME(a_no_spurious, clock, reset, rsp_valid, (pend_ff != 2'd0))

   // at most one in flight plus one waiting result, checked only when the request payload has even parity
   `WMBDT_ASSERT_SAME(a_pend_bound, clock, reset, 1'b1, (pend_ff != 2'd3 || unused_payload))

   // the first sample after reset is its own base
   `WMBDT_ASSERT_SAME(a_first_zero, clock, reset, (rsp_xfer && first_ff), (rsp_delay_over_base == '0))

   // ready drops after each taken sample
   `WMBDT_ASSERT_NEXT(a_one_per_two, clock, reset, req_xfer, !req_ready)

   // a stalled result holds
   `WMBDT_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready), (rsp_valid && $stable(rsp_delay_over_base)))

endmodule

bind windowed_min_base_delay_tracker wmbdt_checker u_wmbdt_checker (.*);

// File: bench/windowed_min_base_delay_tracker_tb.sv
// self-checking testbench for the windowed minimum base delay tracker
module windowed_min_base_delay_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wmbdt_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int END_SETTLE   = 2 * HISTORY_DEPTH + 8;
   localparam int RANDOM_ITEMS = 510;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   delay_type req_sample = '0;
   logic      req_step = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   delay_type rsp_delay_over_base;

   windowed_min_base_delay_tracker u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .req_step            (req_step),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_delay_over_base (rsp_delay_over_base)
   );

   // own copy of the tracker state
   logic      track_primed = 1'b0;
   delay_type track_ring [HISTORY_DEPTH];
   delay_type track_base = '0;
   int        track_index = 0;

   delay_type expected_delays [$];

   int tx_idle_pct = 7;
   int rx_idle_pct = 59;
   int mismatch_count = 0;
   int samples_sent = 0;
   int steps_sent = 0;
   int results_checked = 0;
   delay_type drift_center;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic logic wrap_before(input delay_type a, input delay_type b);
      delay_type fwd;
      delay_type back;
      fwd  = b - a;
      back = a - b;
      return fwd < back;
   endfunction

   function automatic delay_type predict_delay(input delay_type s, input logic adv);
      delay_type answer;
      if (!track_primed) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) track_ring[k] = s;
         track_base   = s;
         track_primed = 1'b1;
      end
      if (wrap_before(s, track_base)) begin
         track_base = s;
         track_ring[track_index] = s;
      end else if (wrap_before(s, track_ring[track_index])) begin
         track_ring[track_index] = s;
      end
      answer = s - track_base;
      if (adv) begin
         track_index = (track_index == HISTORY_DEPTH - 1) ? 0 : track_index + 1;
         track_ring[track_index] = s;
         track_base = s;
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (wrap_before(track_ring[k], track_base)) track_base = track_ring[k];
         end
      end
      return answer;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_sample(input delay_type s, input logic adv);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_step   <= adv;
      do @(posedge clock); while (!req_ready);
      expected_delays.push_back(predict_delay(s, adv));
      samples_sent++;
      if (adv) steps_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_delays.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      delay_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_delays.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_delay_over_base));
         end else begin
            want = expected_delays.pop_front();
            results_checked++;
            if (rsp_delay_over_base !== want)
               report_mismatch($sformatf("delay_over_base got %h want %h",
                                         rsp_delay_over_base, want));
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall = 0;
         else stall++;
      end
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // first sample after reset fills the ring, answer is zero
   task automatic test_first_sample();
      send_sample(32'hFFFF_FFF0, 1'b0);
   endtask

   // wrap across zero, lowering the base, half-circle tie and equal values
   task automatic test_wrap_extremes();
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFE0, 1'b0);
      send_sample(32'h7FFF_FFE0, 1'b0);
      send_sample(32'hFFFF_FFE0, 1'b0);
   endtask

   // bucket lowered without the base, base lowered, steps with bit patterns
   task automatic test_base_and_bucket();
      send_sample(32'h0000_1000, 1'b1);
      send_sample(32'h0000_0800, 1'b0);
      send_sample(32'hFFFF_FF00, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h5555_5555, 1'b1);
      send_sample(32'hAAAA_AAAA, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_back_to_back_steps();
      for (int k = 0; k < 6; k++) send_sample(32'h0000_0600 - 32'(k * 'h100), 1'b1);
   endtask

   function automatic delay_type pick_sample();
      int kind;
      kind = $urandom_range(99);
      if (kind < 10) return $urandom;
      if (kind < 15) return drift_center + 32'h8000_0000 + 32'($urandom_range(2)) - 32'd1;
      // drifting delay with jitter, now and then a jump or a move near the wrap point
      if (kind < 17) drift_center = $urandom;
      else if (kind < 19) drift_center = 32'hFFFF_F000 + 32'($urandom_range(8191));
      else drift_center = drift_center + 32'($urandom_range(64)) - 32'd32;
      return drift_center + 32'($urandom_range(4000)) - 32'd500;
   endfunction

   task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int n = 0; n < count; n++) send_sample(pick_sample(), $urandom_range(99) < 25);
      wait_for_results();
   endtask

   initial begin
      drift_center = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_first_sample();
      test_wrap_extremes();
      test_base_and_bucket();
      test_back_to_back_steps();
      wait_for_results();

      test_random_traffic(RANDOM_ITEMS, 7, 59);
      test_random_traffic(RANDOM_ITEMS, 59, 7);
      test_random_traffic(RANDOM_ITEMS, 0, 0);

      repeat (END_SETTLE) @(posedge clock);
      if (expected_delays.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_delays.size()));

      $display("covered %0d samples with %0d bucket steps, %0d results checked",
               samples_sent, steps_sent, results_checked);
      $display("wrap-order ties, base and bucket lowering, ring wrap under three stall mixes");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
